[rtl/mlfqs_pkg.sv]
// mlfqs_pkg: shared constants, opcodes and saturation helper of the
// mlfq scheduler statistics block; no dependencies
package mlfqs_pkg;

  localparam int MAX_PRIORITY_DEF = 63;
  localparam int MAX_READY_DEF    = 64;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int OPCODE_W  = 2;
  localparam int READY_W   = 7;
  localparam int CPU_W     = 32;
  localparam int NICE_W    = 6;
  localparam int PRIO_W    = 6;
  localparam int CNT_W     = 8;
  localparam int MUL_STEPS = 32;
  localparam int MUL_CW    = $clog2(MUL_STEPS);

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RECENT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PRIO   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_REPORT = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh7FFF_FFFF;
    lo = -65'sh8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/mlfqs_item_if.sv]
// mlfqs_item_if: input channel of the scheduler statistics block
// depends on mlfqs_pkg
interface mlfqs_item_if
  import mlfqs_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [READY_W-1:0]         ready_count;
  logic                       running_busy;
  logic signed [CPU_W-1:0]    thread_cpu_hist;
  logic signed [NICE_W-1:0]   thread_nice;

  modport source (output valid, opcode, ready_count, running_busy, thread_cpu_hist,
                  thread_nice, input ready);
  modport sink (input valid, opcode, ready_count, running_busy, thread_cpu_hist,
                thread_nice, output ready);
endinterface

[rtl/mlfqs_result_if.sv]
// mlfqs_result_if: result channel of the scheduler statistics block
// depends on mlfqs_pkg
interface mlfqs_result_if
  import mlfqs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CPU_W-1:0]  load_average;
  logic signed [CPU_W-1:0]  next_cpu_hist;
  logic [PRIO_W-1:0]        sched_prio;
  logic signed [CPU_W-1:0]  load_times_hundred;
  logic signed [CPU_W-1:0]  recent_times_hundred;

  modport source (output valid, load_average, next_cpu_hist, sched_prio,
                  load_times_hundred, recent_times_hundred, input ready);
  modport sink (input valid, load_average, next_cpu_hist, sched_prio,
                load_times_hundred, recent_times_hundred, output ready);
endinterface

[rtl/mlfqs_div.sv]
// mlfqs_div: bit-serial restoring divider, one quotient bit per cycle
// unsigned operands of W bits; no dependencies
module mlfqs_div #(
  parameter int W = 49
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic          active;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  den_r;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(W);
        rem    <= '0;
        quo    <= num;
        den_r  <= den;
      end else if (active) begin
        rem <= ge ? diff[W-1:0] : trial[W-1:0];
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !active)
    else $error("divider restarted while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) done |-> rem < den_r)
    else $error("divider remainder not below divisor");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) active |-> cnt != '0)
    else $error("divider active with no steps left");

endmodule

[rtl/mlfq_scheduler_statistics.sv]
// mlfq_scheduler_statistics: load average, recent cpu and priority unit of a
// multi-level feedback queue scheduler, signed fixed point with FRAC_BITS
// fraction bits; depends on mlfqs_pkg, mlfqs_item_if, mlfqs_result_if, mlfqs_div
//
// usage: one item beat on "item" gives exactly one result beat on "result".
// opcode 0 updates the kept load average, opcode 1 computes a new recent cpu
// from the load average, opcodes 2 and 3 pass the recent cpu through. every
// result carries the load average, recent cpu, priority and both values
// times 100, rounded half away from zero.
// steps per opcode:
//   opcode 0: two passes of the bit-serial divider
//   opcode 1: divider pass, then 32-step serial multiplier; the divider
//     is skipped when 2*load + 1 is zero
//   opcodes 2 and 3: straight to the times-100 and output steps
// the serial divider and multiplier set the pace; the next beat is taken
// the cycle after the result is loaded
// one item is in work at a time; item.ready is high while the sequencer is
// free, also while a finished result waits in the output register.
// a stalled receiver holds the result register; the next item runs up to its
// last step and then waits for the register to drain.
// reset (synchronous, active high) clears the load average to zero and
// drops any pending result.
module mlfq_scheduler_statistics
  import mlfqs_pkg::*;
#(
  parameter int MAX_PRIORITY = MAX_PRIORITY_DEF,
  parameter int MAX_READY    = MAX_READY_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  mlfqs_item_if.sink     item,
  mlfqs_result_if.source result
);
  localparam int MW  = FRAC_BITS + 33;
  localparam int PRW = FRAC_BITS + 26;
  localparam logic [MW-1:0]          DEN60   = MW'(60);
  localparam logic signed [33:0]     ONE34   = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [PRW-1:0]  MAXP_FX = PRW'(MAX_PRIORITY) <<< FRAC_BITS;
  localparam logic signed [PRW-1:0]  SAT_HI  = {(PRW-31)'(0), {31{1'b1}}};
  localparam logic [PRW-1:0]         MAXP_W  = PRW'(MAX_PRIORITY);
  localparam logic [38:0]            HALF39  = 39'(1) << (FRAC_BITS - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIVA = 8'b0000_0010,
    S_DIVB = 8'b0000_0100,
    S_DIVC = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_FIX  = 8'b0010_0000,
    S_X100 = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  function automatic logic signed [31:0] round_fx(input logic signed [38:0] v);
    logic [38:0] m;
    logic [38:0] r;
    m = v[38] ? 39'(-v) : 39'(v);
    r = (m + HALF39) >> FRAC_BITS;
    return v[38] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  state_t                   state;
  logic signed [31:0]       load_avg;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [31:0]       new_rc;
  logic signed [NICE_W-1:0] nice_r;
  logic signed [31:0]       a_r;
  logic [31:0]              mcand;
  logic [31:0]              hi;
  logic [31:0]              lo;
  logic                     prod_neg;
  logic [MUL_CW-1:0]        mul_cnt;
  logic signed [38:0]       l100;
  logic signed [38:0]       r100;
  logic [PRIO_W-1:0]        prio;

  logic                     out_valid;
  logic                     out_load_en;
  logic signed [31:0]       out_load;
  logic signed [31:0]       out_rc;
  logic [PRIO_W-1:0]        out_prio;
  logic signed [31:0]       out_l100;
  logic signed [31:0]       out_r100;

  logic                     div_start;
  logic [MW-1:0]            div_num;
  logic [MW-1:0]            div_den;
  logic                     div_done;
  logic [MW-1:0]            div_quo;

  // operand prep
  logic signed [37:0]       l59;
  logic [37:0]              mag59;
  logic [32:0]              tw_mag;
  logic signed [33:0]       den1;
  logic [33:0]              den1_mag;
  logic [READY_W-1:0]       rdy_sat;
  logic [CNT_W-1:0]         cnt_in;
  logic [31:0]              item_rc_mag;
  logic [31:0]              rc_mag;
  logic                     c_neg;
  logic [31:0]              coef_mag;
  logic signed [64:0]       sum_b;
  logic signed [64:0]       sp;
  logic signed [64:0]       fix_v;
  logic signed [32:0]       rcx;
  logic signed [32:0]       rc4;
  logic signed [PRW-1:0]    pval;
  logic signed [PRW-1:0]    ppos;
  logic [PRW-1:0]           pq;
  logic [PRW-1:0]           pcl;

  assign l59      = $signed({{6{load_avg[31]}}, load_avg}) * 38'sd59;
  assign mag59    = l59[37] ? 38'(-l59) : 38'(l59);
  assign tw_mag   = load_avg[31] ? 33'(-$signed({load_avg, 1'b0})) : {load_avg, 1'b0};
  assign den1     = $signed({load_avg[31], load_avg, 1'b0}) + ONE34;
  assign den1_mag = den1[33] ? 34'(-den1) : 34'(den1);
  assign rdy_sat  = (32'(item.ready_count) > 32'(MAX_READY)) ? READY_W'(MAX_READY)
                                                             : item.ready_count;
  assign cnt_in   = CNT_W'(rdy_sat) + CNT_W'(item.running_busy);
  assign item_rc_mag = item.thread_cpu_hist[31] ? 32'(-item.thread_cpu_hist)
                                                : 32'(item.thread_cpu_hist);
  assign rc_mag   = new_rc[31] ? 32'(-new_rc) : 32'(new_rc);

  assign c_neg    = load_avg[31] ^ den1[33];
  always_comb begin
    if (!c_neg) begin
      coef_mag = (div_quo > MW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[31:0];
    end else begin
      coef_mag = (div_quo > MW'(32'h8000_0000)) ? 32'h8000_0000 : div_quo[31:0];
    end
  end

  assign sum_b = 65'(a_r) + $signed(65'(div_quo[31:0]));
  assign sp    = prod_neg ? -$signed({1'b0, hi, lo}) : $signed({1'b0, hi, lo});
  assign fix_v = (sp >>> FRAC_BITS) + (65'(nice_r) <<< FRAC_BITS);

  // priority from truncated rc/4
  assign rcx  = 33'(new_rc) + (new_rc[31] ? 33'sd3 : 33'sd0);
  assign rc4  = rcx >>> 2;
  assign pval = MAXP_FX - PRW'(rc4) - (PRW'(nice_r) <<< (FRAC_BITS + 1));
  assign ppos = (pval > SAT_HI) ? SAT_HI : pval;
  assign pq   = PRW'(ppos) >> FRAC_BITS;
  assign pcl  = pval[PRW-1] ? '0 : ((pq > MAXP_W) ? MAXP_W : pq);

  assign item.ready  = (state == S_IDLE);
  assign out_load_en = (state == S_DONE) && (!out_valid || result.ready);

  always_comb begin
    div_start = 1'b0;
    div_num   = MW'(mag59);
    div_den   = DEN60;
    unique case (state)
      S_IDLE: begin
        if (item.valid && item.opcode == OP_LOAD) begin
          div_start = 1'b1;
        end else if (item.valid && item.opcode == OP_RECENT && den1 != '0) begin
          div_start = 1'b1;
          div_num   = MW'(tw_mag) << FRAC_BITS;
          div_den   = MW'(den1_mag);
        end
      end
      S_DIVA: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = MW'(cnt_r) << FRAC_BITS;
        end
      end
      default: begin
      end
    endcase
  end

  mlfqs_div #(
    .W(MW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      load_avg  <= '0;
      out_valid <= 1'b0;
      mul_cnt   <= '0;
    end else begin
      if (out_load_en) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            cnt_r  <= cnt_in;
            new_rc <= item.thread_cpu_hist;
            nice_r <= item.thread_nice;
            priority if (item.opcode == OP_LOAD) begin
              state <= S_DIVA;
            end else if (item.opcode == OP_RECENT && den1 == '0) begin
              mcand    <= 32'h8000_0000;
              hi       <= '0;
              lo       <= item_rc_mag;
              prod_neg <= ~item.thread_cpu_hist[31];
              mul_cnt  <= '0;
              state    <= S_MUL;
            end else if (item.opcode == OP_RECENT) begin
              state <= S_DIVC;
            end else begin
              state <= S_X100;
            end
          end
        end
        S_DIVA: begin
          if (div_done) begin
            a_r   <= load_avg[31] ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
            state <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            load_avg <= sat32(sum_b);
            state    <= S_X100;
          end
        end
        S_DIVC: begin
          if (div_done) begin
            mcand    <= coef_mag;
            hi       <= '0;
            lo       <= rc_mag;
            prod_neg <= c_neg ^ new_rc[31];
            mul_cnt  <= '0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          // shift-add, one multiplier bit a cycle
          {hi, lo} <= {33'({1'b0, hi} + (lo[0] ? {1'b0, mcand} : 33'd0)), lo[31:1]};
          mul_cnt  <= mul_cnt + MUL_CW'(1);
          if (mul_cnt == MUL_CW'(MUL_STEPS - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          new_rc <= sat32(fix_v);
          state  <= S_X100;
        end
        S_X100: begin
          l100  <= $signed({{7{load_avg[31]}}, load_avg}) * 39'sd100;
          r100  <= $signed({{7{new_rc[31]}}, new_rc}) * 39'sd100;
          prio  <= pcl[PRIO_W-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load_en) begin
            out_load  <= load_avg;
            out_rc    <= new_rc;
            out_prio  <= prio;
            out_l100  <= round_fx(l100);
            out_r100  <= round_fx(r100);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid                = out_valid;
  assign result.load_average         = out_load;
  assign result.next_cpu_hist        = out_rc;
  assign result.sched_prio           = out_prio;
  assign result.load_times_hundred   = out_l100;
  assign result.recent_times_hundred = out_r100;

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("second item taken while one is in work");
  a_load_upd: assert property (@(posedge clk) disable iff (rst)
    load_avg != $past(load_avg) |-> $past(state) == S_DIVB)
    else $error("load average changed outside its update step");
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!out_valid || result.ready) |=> result.valid && state == S_IDLE)
    else $error("finished result not presented");
  a_div_src: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_IDLE || state == S_DIVA)
    else $error("divider started from an unexpected step");

endmodule

[tb/mlfq_scheduler_statistics_tb.sv]
// mlfq_scheduler_statistics_tb: self-checking bench that predicts load average, recent cpu,
// priority and rounded reports per beat and compares every result beat in order
// depends on mlfqs_pkg, mlfqs_item_if, mlfqs_result_if and the block itself
module mlfq_scheduler_statistics_tb
  import mlfqs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RESET_CYCLES = 12;
  localparam int     RANDOM_ITEMS = 1200;
  localparam int     CHUNK        = 150;
  localparam int     QUIET_LIMIT  = 4000;
  localparam int     DRAIN_CYCLES = 2 * (FRAC_BITS_DEF + 33) + 20;
  localparam int     MAX_REPORTS  = 40;
  localparam longint ONE_FX       = 64'sd1 << FRAC_BITS_DEF;
  localparam longint WORD_MAX     = 64'sd2147483647;
  localparam longint WORD_MIN     = -64'sd2147483648;

  typedef struct {
    logic [OPCODE_W-1:0]     opcode;
    logic [READY_W-1:0]      ready_count;
    logic                    running_busy;
    logic signed [CPU_W-1:0] cpu_hist;
    logic signed [NICE_W-1:0] nice;
  } sched_item_t;

  typedef struct {
    logic signed [CPU_W-1:0] load_average;
    logic signed [CPU_W-1:0] next_cpu_hist;
    logic [PRIO_W-1:0]       sched_prio;
    logic signed [CPU_W-1:0] load_x100;
    logic signed [CPU_W-1:0] recent_x100;
  } sched_stats_t;

  class stats_scoreboard;
    longint       load_fx;
    sched_stats_t pending_stats[$];
    int           errors;
    int           reports;

    function new();
      load_fx = 0;
      errors  = 0;
      reports = 0;
    endfunction

    function longint sat_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
    endfunction

    // half away from zero
    function longint round_fx(longint v);
      if (v >= 0) return (v + ONE_FX / 2) / ONE_FX;
      return (v - ONE_FX / 2) / ONE_FX;
    endfunction

    function void note_item(sched_item_t it);
      longint       ready_v;
      longint       busy_v;
      longint       rc;
      longint       nice_v;
      longint       new_rc;
      longint       twice;
      longint       den;
      longint       coef;
      longint       prio;
      sched_stats_t s;
      ready_v = it.ready_count;
      if (ready_v > MAX_READY_DEF) ready_v = MAX_READY_DEF;
      busy_v = it.running_busy;
      rc     = it.cpu_hist;
      nice_v = it.nice;
      new_rc = rc;
      case (it.opcode)
        OP_LOAD: begin
          load_fx = sat_word((load_fx * 59) / 60 + ((ready_v + busy_v) * ONE_FX) / 60);
        end
        OP_RECENT: begin
          twice = load_fx * 2;
          den   = twice + ONE_FX;
          if (den == 0) coef = WORD_MIN;
          else coef = sat_word((twice * ONE_FX) / den);
          new_rc = sat_word(((coef * rc) >>> FRAC_BITS_DEF) + nice_v * ONE_FX);
        end
        default: ;
      endcase
      prio = MAX_PRIORITY_DEF * ONE_FX - new_rc / 4 - 2 * nice_v * ONE_FX;
      prio = sat_word(prio) / ONE_FX;
      if (prio > MAX_PRIORITY_DEF) prio = MAX_PRIORITY_DEF;
      if (prio < 0) prio = 0;
      s.load_average  = CPU_W'(sat_word(load_fx));
      s.next_cpu_hist = CPU_W'(sat_word(new_rc));
      s.sched_prio    = PRIO_W'(prio);
      s.load_x100     = CPU_W'(sat_word(round_fx(load_fx * 100)));
      s.recent_x100   = CPU_W'(sat_word(round_fx(new_rc * 100)));
      pending_stats.push_back(s);
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
        end
      end
    endfunction

    function void check_result(sched_stats_t got);
      sched_stats_t want;
      if (pending_stats.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t result beat with nothing pending: expected none actual load %0d",
                   $time, got.load_average);
        end
        return;
      end
      want = pending_stats.pop_front();
      compare("load_average", want.load_average, got.load_average);
      compare("next_cpu_hist", want.next_cpu_hist, got.next_cpu_hist);
      compare("sched_prio", want.sched_prio, got.sched_prio);
      compare("load_times_hundred", want.load_x100, got.load_x100);
      compare("recent_times_hundred", want.recent_x100, got.recent_x100);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;

  stats_scoreboard sb = new();

  mlfqs_item_if   item_ch();
  mlfqs_result_if result_ch();

  mlfq_scheduler_statistics u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic sched_item_t make_item(logic [OPCODE_W-1:0] op, int ready_n, int busy,
                                            logic signed [CPU_W-1:0] rc, int nice_v);
    sched_item_t it;
    it.opcode       = op;
    it.ready_count  = READY_W'(ready_n);
    it.running_busy = busy[0];
    it.cpu_hist     = rc;
    it.nice         = NICE_W'(nice_v);
    return it;
  endfunction

  function automatic sched_item_t random_item(int ready_top);
    sched_item_t it;
    int          pick;
    pick = $urandom_range(99);
    it.opcode = (pick < 30) ? OP_LOAD : (pick < 60) ? OP_RECENT :
                (pick < 80) ? OP_PRIO : OP_REPORT;
    if ($urandom_range(9) == 0) it.ready_count = READY_W'($urandom_range(127));
    else it.ready_count = READY_W'($urandom_range(ready_top));
    it.running_busy = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: it.cpu_hist = $urandom;
      1: it.cpu_hist = int'($urandom_range(2 ** 24 - 1)) - 2 ** 23;
      2: it.cpu_hist = (int'($urandom_range(255)) - 128) * 65536;
      default: begin
        if ($urandom_range(1)) it.cpu_hist = 32'sh7FFF_FFFF - $urandom_range(3);
        else it.cpu_hist = 32'sh8000_0000 + $urandom_range(3);
      end
    endcase
    if ($urandom_range(3) == 0) it.nice = NICE_W'($urandom_range(63));
    else it.nice = NICE_W'(int'($urandom_range(40)) - 20);
    return it;
  endfunction

  task automatic send_item(sched_item_t it);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) begin
      if ($urandom_range(3) == 0) gap = $urandom_range(1, 140);
      else gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.opcode          <= it.opcode;
    item_ch.ready_count     <= it.ready_count;
    item_ch.running_busy    <= it.running_busy;
    item_ch.thread_cpu_hist <= it.cpu_hist;
    item_ch.thread_nice     <= it.nice;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(it);
  endtask

  always @(posedge clk) begin
    sched_stats_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.load_average  = result_ch.load_average;
      got.next_cpu_hist = result_ch.next_cpu_hist;
      got.sched_prio    = result_ch.sched_prio;
      got.load_x100     = result_ch.load_times_hundred;
      got.recent_x100   = result_ch.recent_times_hundred;
      sb.check_result(got);
    end
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ready_top;
    rst                     = 1'b1;
    quiet_cycles            = 0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    item_ch.valid           = 1'b0;
    item_ch.opcode          = OP_REPORT;
    item_ch.ready_count     = '0;
    item_ch.running_busy    = 1'b0;
    item_ch.thread_cpu_hist = '0;
    item_ch.thread_nice     = '0;
    result_ch.ready         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // zero load, clamps at both ends, rounding of exact halves
    send_item(make_item(OP_REPORT, 0, 0, 0, 0));
    send_item(make_item(OP_RECENT, 0, 0, 32'sh7FFF_FFFF, -32));
    send_item(make_item(OP_PRIO, 127, 1, 32'sh8000_0000, 31));
    send_item(make_item(OP_PRIO, 0, 0, 32'sh7FFF_FFFF, -32));
    send_item(make_item(OP_REPORT, 127, 1, 8192, 0));
    send_item(make_item(OP_REPORT, 0, 0, -8192, 0));
    send_item(make_item(OP_REPORT, 0, 1, -655, 5));
    // load updates, ready count beyond the cap
    send_item(make_item(OP_LOAD, 127, 1, 0, 0));
    send_item(make_item(OP_LOAD, 65, 0, 12345, -1));
    send_item(make_item(OP_LOAD, 64, 1, 0, 0));
    send_item(make_item(OP_LOAD, 0, 0, 0, 0));
    send_item(make_item(OP_LOAD, 1, 1, 0, 0));
    send_item(make_item(OP_LOAD, 100, 0, 0, 0));
    // recent cpu with saturation both ways, then priority and report items
    send_item(make_item(OP_RECENT, 0, 0, 32'sh7FFF_FFFF, 31));
    send_item(make_item(OP_RECENT, 0, 0, 32'sh8000_0000, -32));
    send_item(make_item(OP_RECENT, 3, 1, -1, 0));
    send_item(make_item(OP_RECENT, 0, 0, 100 * 65536, -20));
    send_item(make_item(OP_PRIO, 0, 0, 0, 20));
    send_item(make_item(OP_PRIO, 0, 0, 0, -20));
    send_item(make_item(OP_PRIO, 0, 0, -3, 0));
    send_item(make_item(OP_REPORT, 127, 1, 32'sh8000_0000, 0));
    send_item(make_item(OP_REPORT, 0, 0, 32'sh7FFF_FFFF, 0));

    for (int chunk = 0; chunk < RANDOM_ITEMS / CHUNK; chunk++) begin
      case (chunk % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      case ($urandom_range(2))
        0: ready_top = 2;
        1: ready_top = 64;
        default: ready_top = 127;
      endcase
      repeat (CHUNK) send_item(random_item(ready_top));
    end
    item_ch.valid <= 1'b0;

    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_stats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
